// ===== sv/clamp_point_to_nearest_circle_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the circle clamp block
// Shorthand for clocked implications that are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef CLAMP_POINT_TO_NEAREST_CIRCLE_MACROS_SVH
`define CLAMP_POINT_TO_NEAREST_CIRCLE_MACROS_SVH

// Same-cycle implication.
`define CPNC_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CPNC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/cpnc_pkg.sv =====
// ----------------------------------------------------------------------------
// cpnc_pkg
// Shared constants, types and helpers of the circle clamp block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpnc_pkg;

   localparam int MAX_REGIONS = 16;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int ENTRY_W     = 32 + 32 + 31;

   localparam logic [1:0] FUNC_LOAD = 2'd0;
   localparam logic [1:0] FUNC_HOME = 2'd1;
   localparam logic [1:0] FUNC_SEQ  = 2'd2;

   typedef enum logic [1:0] {
      OP_MUL,
      OP_SQRT,
      OP_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

   // Magnitude of a 33-bit two's complement difference of two 32-bit values.
   function automatic logic [31:0] mag33(input logic [32:0] v);
      logic [32:0] n;
      n = -v;
      return v[32] ? n[31:0] : v[31:0];
   endfunction

   // Saturate a 34-bit signed sum to the signed 32-bit range.
   function automatic logic [31:0] sat32(input logic [33:0] v);
      logic [31:0] r;
      if (!v[33] && (v[32:31] != 2'b00)) begin
         r = 32'h7fff_ffff;
      end else if (v[33] && (v[32:31] != 2'b11)) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/cpnc_ram.sv =====
// ----------------------------------------------------------------------------
// cpnc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpnc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/cpnc_alu.sv =====
// ----------------------------------------------------------------------------
// cpnc_alu
// Bit-serial arithmetic unit: shift-add multiply, restoring square root and
// restoring division, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "clamp_point_to_nearest_circle_macros.svh"

module cpnc_alu (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cpnc_pkg::alu_cmd_type cmd,
   input  wire logic [65:0]           opa,
   input  wire logic [33:0]           opb,
   output cpnc_pkg::alu_stat_type     stat,
   output logic      [63:0]           prod,
   output logic      [63:0]           quot,
   output logic      [32:0]           root
);

   import cpnc_pkg::*;

   localparam logic [6:0] MUL_LAST  = 7'd31;
   localparam logic [6:0] SQRT_LAST = 7'd32;
   localparam logic [6:0] DIV_LAST  = 7'd63;

   alu_op_type  op_ff,   op_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [6:0]  cnt_ff,  cnt_in;
   logic [65:0] a_ff,    a_in;
   logic [33:0] b_ff,    b_in;
   logic [65:0] p_ff,    p_in;
   logic [65:0] rem2, trial, rem1, divisor;

   always_comb begin
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      rem2    = {p_ff[63:0], a_ff[65:64]};
      trial   = {30'd0, b_ff, 2'b01};
      rem1    = {p_ff[64:0], a_ff[65]};
      divisor = {32'd0, b_ff};
      if (cmd.start) begin
         op_in   = cmd.op;
         busy_in = 1'b1;
         p_in    = '0;
         unique case (cmd.op)
            OP_MUL: begin
               cnt_in = MUL_LAST;
               a_in   = opa;
               b_in   = opb;
            end
            OP_SQRT: begin
               cnt_in = SQRT_LAST;
               a_in   = opa;
               b_in   = '0;
            end
            default: begin
               cnt_in = DIV_LAST;
               a_in   = {opa[63:0], 2'b00};
               b_in   = opb;
            end
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_MUL: begin
               if (b_ff[0]) begin
                  p_in = p_ff + a_ff;
               end
               a_in = {a_ff[64:0], 1'b0};
               b_in = {1'b0, b_ff[33:1]};
            end
            OP_SQRT: begin
               // Two radicand bits enter the partial remainder per cycle.
               a_in = {a_ff[63:0], 2'b00};
               if (rem2 >= trial) begin
                  p_in = rem2 - trial;
                  b_in = {b_ff[32:0], 1'b1};
               end else begin
                  p_in = rem2;
                  b_in = {b_ff[32:0], 1'b0};
               end
            end
            default: begin
               // Quotient bits shift in behind the dividend.
               if (rem1 >= divisor) begin
                  p_in = rem1 - divisor;
                  a_in = {a_ff[64:0], 1'b1};
               end else begin
                  p_in = rem1;
                  a_in = {a_ff[64:0], 1'b0};
               end
            end
         endcase
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      p_ff <= p_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign prod      = p_ff[63:0];
   assign quot      = a_ff[63:0];
   assign root      = b_ff[32:0];

   `CPNC_ASSERT_NEXT(a_start_busy, cmd.start, busy_ff && !done_ff, "alu did not start")
   `CPNC_ASSERT_NEXT(a_last_done, busy_ff && !cmd.start && cnt_ff == 7'd0,
      done_ff && !busy_ff, "alu did not finish after its last step")
   `CPNC_ASSERT_NEXT(a_done_pulse, done_ff, !done_ff, "alu done lasted more than one cycle")

endmodule

`default_nettype wire

// ===== sv/clamp_point_to_nearest_circle.sv =====
// ----------------------------------------------------------------------------
// clamp_point_to_nearest_circle
// Circle table with projection of a point onto the edge of a chosen circle.
// ----------------------------------------------------------------------------
//   channel   ports                      direction   transfer when
//   request   req_valid / req_stall      in          valid high, stall low
//   response  rsp_valid / rsp_stall      out         valid high, stall low
//   control   csr_wr_en / csr_wr_data    in          write enable high
//
// A clamp by sequence runs, on one bit-serial unit, a modulo, three squares, a
// root, two multiplies and two divides. A clamp by home skips the modulo and
// adds two squares per entry in use; a point inside its circle skips the root,
// multiplies and divides.
// Reset is synchronous and clears control state only; the table is not reset.
// req_stall is high while an item is at work; a held response does not stop
// the next request from being taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "clamp_point_to_nearest_circle_macros.svh"

module clamp_point_to_nearest_circle (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [3:0]  req_entry_index,
   input  wire logic [30:0] req_sequence_req,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_home_x,
   input  wire logic [31:0] req_home_y,
   input  wire logic [31:0] req_center_x,
   input  wire logic [31:0] req_center_y,
   input  wire logic [30:0] req_radius,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_out_x,
   output logic [31:0]      rsp_out_y,
   output logic             rsp_was_clamped,
   output logic [3:0]       rsp_chosen_index,
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data
);

   import cpnc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_MOD_GO, S_MOD_W,
      S_SCAN_RD, S_SCAN_LD, S_HX_GO, S_HX_W, S_HY_GO, S_HY_W,
      S_SEL_RD, S_SEL_LD, S_PX_GO, S_PX_W, S_PY_GO, S_PY_W, S_RR_GO, S_RR_W,
      S_SQ_GO, S_SQ_W, S_MX_GO, S_MX_W, S_DX_GO, S_DX_W,
      S_MY_GO, S_MY_W, S_DY_GO, S_DY_W, S_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [4:0]       count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic             rsp_cl_ff, rsp_cl_in;
   logic [IDX_W-1:0] rsp_idx_ff, rsp_idx_in;

   logic [31:0]      px_ff, px_in, py_ff, py_in, hx_ff, hx_in, hy_ff, hy_in;
   logic [30:0]      seq_ff, seq_in;
   logic [31:0]      cx_ff, cx_in, cy_ff, cy_in;
   logic [30:0]      rad_ff, rad_in;
   logic [IDX_W:0]   i_ff, i_in;
   logic [IDX_W-1:0] bidx_ff, bidx_in;
   logic [64:0]      best_ff, best_in, d2_ff, d2_in;
   logic [32:0]      dist_ff, dist_in;
   logic [30:0]      qx_ff, qx_in;
   logic [31:0]      ox_ff, ox_in, oy_ff, oy_in;
   logic             cl_ff, cl_in;

   logic [4:0]       cnt_eff;
   logic             slot_free;
   logic [32:0]      dx_p, dy_p, dx_h, dy_h;
   logic [31:0]      mag_px, mag_py, mag_hx, mag_hy;
   logic [64:0]      scan_sum;
   logic [33:0]      sum_x, sum_y;

   alu_cmd_type      alu_cmd;
   alu_stat_type     alu_stat;
   logic [65:0]      alu_opa;
   logic [33:0]      alu_opb;
   logic [63:0]      alu_prod, alu_quot;
   logic [32:0]      alu_root;

   logic             ram_we;
   logic [IDX_W-1:0] ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   cpnc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REGIONS)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_entry_index[IDX_W-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   cpnc_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .opa   (alu_opa),
      .opb   (alu_opb),
      .stat  (alu_stat),
      .prod  (alu_prod),
      .quot  (alu_quot),
      .root  (alu_root)
   );

   assign ram_wdata = {req_center_x, req_center_y, req_radius};
   assign ram_raddr = (state_ff == S_SEL_RD) ? bidx_ff : i_ff[IDX_W-1:0];

   // A count of zero acts as one; a count beyond the table acts as its size.
   always_comb begin
      if (count_ff == 5'd0) begin
         cnt_eff = 5'd1;
      end else if (32'(count_ff) > MAX_REGIONS) begin
         cnt_eff = 5'(MAX_REGIONS);
      end else begin
         cnt_eff = count_ff;
      end
   end

   assign dx_p   = {px_ff[31], px_ff} - {cx_ff[31], cx_ff};
   assign dy_p   = {py_ff[31], py_ff} - {cy_ff[31], cy_ff};
   assign dx_h   = {cx_ff[31], cx_ff} - {hx_ff[31], hx_ff};
   assign dy_h   = {cy_ff[31], cy_ff} - {hy_ff[31], hy_ff};
   assign mag_px = mag33(dx_p);
   assign mag_py = mag33(dy_p);
   assign mag_hx = mag33(dx_h);
   assign mag_hy = mag33(dy_h);

   assign scan_sum  = d2_ff + 65'(alu_prod);
   assign sum_x     = {{2{cx_ff[31]}}, cx_ff}
                      + (dx_p[32] ? -{3'd0, qx_ff} : {3'd0, qx_ff});
   assign sum_y     = {{2{cy_ff[31]}}, cy_ff}
                      + (dy_p[32] ? -{3'd0, alu_quot[30:0]} : {3'd0, alu_quot[30:0]});
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = csr_wr_en ? csr_wr_data : count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_cl_in    = rsp_cl_ff;
      rsp_idx_in   = rsp_idx_ff;
      px_in   = px_ff;   py_in   = py_ff;   hx_in = hx_ff; hy_in = hy_ff;
      seq_in  = seq_ff;  cx_in   = cx_ff;   cy_in = cy_ff; rad_in = rad_ff;
      i_in    = i_ff;    bidx_in = bidx_ff; best_in = best_ff; d2_in = d2_ff;
      dist_in = dist_ff; qx_in   = qx_ff;
      ox_in   = ox_ff;   oy_in   = oy_ff;   cl_in = cl_ff;
      ram_we        = 1'b0;
      alu_cmd.start = 1'b0;
      alu_cmd.op    = OP_MUL;
      alu_opa       = '0;
      alu_opb       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               px_in   = req_pos_x;
               py_in   = req_pos_y;
               hx_in   = req_home_x;
               hy_in   = req_home_y;
               seq_in  = req_sequence_req;
               ox_in   = '0;
               oy_in   = '0;
               cl_in   = 1'b0;
               bidx_in = '0;
               i_in    = '0;
               priority case (req_func)
                  FUNC_LOAD: begin
                     ram_we   = (32'(req_entry_index) < MAX_REGIONS);
                     state_in = S_EMIT;
                  end
                  FUNC_HOME: state_in = S_SCAN_RD;
                  FUNC_SEQ:  state_in = S_MOD_GO;
                  default:   state_in = S_EMIT;
               endcase
            end
         end
         S_MOD_GO: begin
            alu_cmd.start = 1'b1;
            alu_cmd.op    = OP_DIV;
            alu_opa       = 66'(seq_ff);
            alu_opb       = 34'(cnt_eff);
            state_in      = S_MOD_W;
         end
         S_MOD_W: begin
            if (alu_stat.done) begin
               bidx_in  = alu_prod[IDX_W-1:0];
               state_in = S_SEL_RD;
            end
         end
         S_SCAN_RD: state_in = S_SCAN_LD;
         S_SCAN_LD: begin
            cx_in    = ram_rdata[94:63];
            cy_in    = ram_rdata[62:31];
            rad_in   = ram_rdata[30:0];
            state_in = S_HX_GO;
         end
         S_HX_GO: begin
            alu_cmd.start = 1'b1;
            alu_opa       = 66'(mag_hx);
            alu_opb       = 34'(mag_hx);
            state_in      = S_HX_W;
         end
         S_HX_W: begin
            if (alu_stat.done) begin
               d2_in    = 65'(alu_prod);
               state_in = S_HY_GO;
            end
         end
         S_HY_GO: begin
            alu_cmd.start = 1'b1;
            alu_opa       = 66'(mag_hy);
            alu_opb       = 34'(mag_hy);
            state_in      = S_HY_W;
         end
         S_HY_W: begin
            if (alu_stat.done) begin
               // Strictly smaller wins, so the lower index keeps a tie.
               if ((i_ff == '0) || (scan_sum < best_ff)) begin
                  best_in = scan_sum;
                  bidx_in = i_ff[IDX_W-1:0];
               end
               i_in = i_ff + 1'b1;
               if ((i_ff + 1'b1) == cnt_eff) begin
                  state_in = S_SEL_RD;
               end else begin
                  state_in = S_SCAN_RD;
               end
            end
         end
         S_SEL_RD: state_in = S_SEL_LD;
         S_SEL_LD: begin
            cx_in    = ram_rdata[94:63];
            cy_in    = ram_rdata[62:31];
            rad_in   = ram_rdata[30:0];
            state_in = S_PX_GO;
         end
         S_PX_GO: begin
            alu_cmd.start = 1'b1;
            alu_opa       = 66'(mag_px);
            alu_opb       = 34'(mag_px);
            state_in      = S_PX_W;
         end
         S_PX_W: begin
            if (alu_stat.done) begin
               d2_in    = 65'(alu_prod);
               state_in = S_PY_GO;
            end
         end
         S_PY_GO: begin
            alu_cmd.start = 1'b1;
            alu_opa       = 66'(mag_py);
            alu_opb       = 34'(mag_py);
            state_in      = S_PY_W;
         end
         S_PY_W: begin
            if (alu_stat.done) begin
               d2_in    = scan_sum;
               state_in = S_RR_GO;
            end
         end
         S_RR_GO: begin
            alu_cmd.start = 1'b1;
            alu_opa       = 66'(rad_ff);
            alu_opb       = 34'(rad_ff);
            state_in      = S_RR_W;
         end
         S_RR_W: begin
            if (alu_stat.done) begin
               if (d2_ff > 65'(alu_prod)) begin
                  state_in = S_SQ_GO;
               end else begin
                  ox_in    = px_ff;
                  oy_in    = py_ff;
                  state_in = S_EMIT;
               end
            end
         end
         S_SQ_GO: begin
            alu_cmd.start = 1'b1;
            alu_cmd.op    = OP_SQRT;
            alu_opa       = 66'(d2_ff);
            state_in      = S_SQ_W;
         end
         S_SQ_W: begin
            if (alu_stat.done) begin
               dist_in  = (alu_root == '0) ? 33'd1 : alu_root;
               state_in = S_MX_GO;
            end
         end
         S_MX_GO: begin
            alu_cmd.start = 1'b1;
            alu_opa       = 66'(rad_ff);
            alu_opb       = 34'(mag_px);
            state_in      = S_MX_W;
         end
         S_MX_W: if (alu_stat.done) state_in = S_DX_GO;
         S_DX_GO: begin
            alu_cmd.start = 1'b1;
            alu_cmd.op    = OP_DIV;
            alu_opa       = 66'(alu_prod);
            alu_opb       = 34'(dist_ff);
            state_in      = S_DX_W;
         end
         S_DX_W: begin
            if (alu_stat.done) begin
               // The offset never exceeds the radius, so 31 bits hold it.
               qx_in    = alu_quot[30:0];
               state_in = S_MY_GO;
            end
         end
         S_MY_GO: begin
            alu_cmd.start = 1'b1;
            alu_opa       = 66'(rad_ff);
            alu_opb       = 34'(mag_py);
            state_in      = S_MY_W;
         end
         S_MY_W: if (alu_stat.done) state_in = S_DY_GO;
         S_DY_GO: begin
            alu_cmd.start = 1'b1;
            alu_cmd.op    = OP_DIV;
            alu_opa       = 66'(alu_prod);
            alu_opb       = 34'(dist_ff);
            state_in      = S_DY_W;
         end
         S_DY_W: begin
            if (alu_stat.done) begin
               ox_in    = sat32(sum_x);
               oy_in    = sat32(sum_y);
               cl_in    = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = ox_ff;
               rsp_y_in     = oy_ff;
               rsp_cl_in    = cl_ff;
               rsp_idx_in   = bidx_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= 5'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_cl_ff  <= rsp_cl_in;
      rsp_idx_ff <= rsp_idx_in;
      px_ff   <= px_in;   py_ff   <= py_in;   hx_ff <= hx_in; hy_ff <= hy_in;
      seq_ff  <= seq_in;  cx_ff   <= cx_in;   cy_ff <= cy_in; rad_ff <= rad_in;
      i_ff    <= i_in;    bidx_ff <= bidx_in; best_ff <= best_in; d2_ff <= d2_in;
      dist_ff <= dist_in; qx_ff   <= qx_in;
      ox_ff   <= ox_in;   oy_ff   <= oy_in;   cl_ff <= cl_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = rsp_x_ff;
   assign rsp_out_y        = rsp_y_ff;
   assign rsp_was_clamped  = rsp_cl_ff;
   assign rsp_chosen_index = rsp_idx_ff;

   `CPNC_ASSERT_NOW(a_start_free, alu_cmd.start, !alu_stat.busy,
      "arithmetic unit started while busy")
   `CPNC_ASSERT_NOW(a_scan_bound, state_ff == S_SCAN_RD, i_ff < cnt_eff,
      "nearest search ran past the entry count")
   `CPNC_ASSERT_NEXT(a_emit, state_ff == S_EMIT && slot_free,
      rsp_valid_ff && state_ff == S_IDLE, "finished result was not presented")

endmodule

`default_nettype wire
